// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of the cache tag store.
// Needs clk and arst_n visible in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SAC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cache tag store check failed");

// Next-cycle implication, disabled while reset is asserted
`define SAC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cache tag store check failed");

`endif

// ===== rtl/sac_pkg.sv =====
// Shared types and fixed field widths of the set-associative cache tag store.
// No dependencies.
package sac_pkg;

	// Port field widths
	localparam int SET_IDX_W = 6;
	localparam int TAG_IN_W  = 32;
	localparam int WAY_OUT_W = 2;
	localparam int CNT_OUT_W = 32;
	localparam int CFG_W     = 3;
	// Internal width of the ways-in-use register, holds up to 16 ways
	localparam int WAYS_REG_W = 5;
	// Way number width inside the lookup result, covers up to 16 ways
	localparam int WAY_IDX_W  = 4;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

	// Lookup decision handed from the compare logic to the controller
	typedef struct packed {
		logic                 hit;
		logic                 fill;
		logic [WAY_IDX_W-1:0] way;
	} lkp_res_t;

endpackage

// ===== rtl/sac_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/sac_lookup.sv =====
// Tag compare and replacement decision for one set read from the RAMs.
// Depends on sac_pkg.
module sac_lookup #(
	parameter int NUM_WAYS = 4,
	parameter int TAG_BITS = 32,
	parameter int CNT_W    = 3,
	parameter int WAY_W    = 2
) (
	input  logic [sac_pkg::WAYS_REG_W-1:0] ways_cfg,
	input  logic [NUM_WAYS*TAG_BITS-1:0]   set_tags,
	input  logic [TAG_BITS-1:0]            key,
	input  logic [CNT_W-1:0]               filled,
	input  logic [WAY_W-1:0]               recent,
	output sac_pkg::lkp_res_t              res
);

	localparam logic [sac_pkg::WAYS_REG_W-1:0] NW_MAX = sac_pkg::WAYS_REG_W'(NUM_WAYS);

	logic [sac_pkg::WAYS_REG_W-1:0] nw;
	logic [sac_pkg::WAYS_REG_W-1:0] filled_x;
	logic [sac_pkg::WAYS_REG_W-1:0] limit;

	// Effective way count: zero acts as one, clamp to the built ways
	always_comb begin
		if (ways_cfg == '0) begin
			nw = sac_pkg::WAYS_REG_W'(1);
		end else if (ways_cfg > NW_MAX) begin
			nw = NW_MAX;
		end else begin
			nw = ways_cfg;
		end
		filled_x = sac_pkg::WAYS_REG_W'(filled);
		limit    = (filled_x < nw) ? filled_x : nw;
	end

	// Lowest matching filled way wins; otherwise pick fill or replace way
	always_comb begin
		res = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if ((sac_pkg::WAYS_REG_W'(w) < limit) &&
			    (set_tags[w*TAG_BITS +: TAG_BITS] == key)) begin
				res.hit = 1'b1;
				res.way = sac_pkg::WAY_IDX_W'(w);
			end
		end
		if (!res.hit) begin
			if (filled_x < nw) begin
				res.fill = 1'b1;
				res.way  = sac_pkg::WAY_IDX_W'(filled);
			end else if (sac_pkg::WAYS_REG_W'(recent) < nw) begin
				res.way = sac_pkg::WAY_IDX_W'(recent);
			end else begin
				res.way = '0;
			end
		end
	end

endmodule

// ===== rtl/set_assoc_cache_mru_replace.sv =====
// Set-associative cache tag store with most-recently-used replacement.
// Results show for one cycle, no stall: done pulses after the start transfer passes
// the compare state and done register. No new access is taken before the last is
// through (RAM read, then compare and write-back, busy high). Reset clears counters
// and control at once, then a clear pass zeroes the per-set fill/recent RAM, busy high.
// Depends on sac_pkg, sac_ram, sac_lookup.
module set_assoc_cache_mru_replace #(
	parameter int NUM_SETS = 64,
	parameter int NUM_WAYS = 4,
	parameter int TAG_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// access command
	input  logic                          start,
	output logic                          busy,
	input  logic [sac_pkg::SET_IDX_W-1:0] set_index,
	input  logic [sac_pkg::TAG_IN_W-1:0]  tag,
	// result strobe and fields
	output logic                          done,
	output logic                          hit,
	output logic [sac_pkg::WAY_OUT_W-1:0] way,
	output logic [sac_pkg::CNT_OUT_W-1:0] hit_count,
	output logic [sac_pkg::CNT_OUT_W-1:0] miss_count,
	// ways-in-use register write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sac_pkg::CFG_W-1:0]     cfg_data
);

	localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int CNT_W  = $clog2(NUM_WAYS + 1);
	localparam int META_W = CNT_W + WAY_W;
	localparam int IDX_N  = 2 ** sac_pkg::SET_IDX_W;
	localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

	typedef logic [SET_W-1:0] set_tab_t [IDX_N];

	// Set index folded onto the built set count
	function automatic set_tab_t build_set_tab();
		set_tab_t t;
		for (int i = 0; i < IDX_N; i++) begin
			t[i] = SET_W'(i % NUM_SETS);
		end
		return t;
	endfunction

	localparam set_tab_t SET_TAB = build_set_tab();

	sac_pkg::state_t                 state_q;
	logic [SET_W-1:0]                clr_q;
	logic [SET_W-1:0]                set_s1;
	logic [TAG_BITS-1:0]             tag_s1;
	logic [sac_pkg::WAYS_REG_W-1:0]  ways_q;
	logic                            done_q;
	logic                            hit_q;
	logic [sac_pkg::WAY_OUT_W-1:0]   way_q;
	logic [sac_pkg::CNT_OUT_W-1:0]   hit_tot_q;
	logic [sac_pkg::CNT_OUT_W-1:0]   miss_tot_q;

	logic                            accept;
	logic                            look;
	logic [SET_W-1:0]                rd_set;
	logic [NUM_WAYS*TAG_BITS-1:0]    set_tags;
	logic [META_W-1:0]               meta_rd;
	logic [META_W-1:0]               meta_wr;
	logic [SET_W-1:0]                meta_waddr;
	logic                            meta_we;
	logic [CNT_W-1:0]                filled;
	logic [WAY_W-1:0]                recent;
	logic [CNT_W-1:0]                new_fill;
	logic [WAY_W-1:0]                pick_way;
	sac_pkg::lkp_res_t               res;

	assign busy      = (state_q != sac_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign look      = (state_q == sac_pkg::ST_LOOK);
	assign cfg_ready = !busy;
	assign rd_set    = SET_TAB[set_index];

	// Tag RAMs, one per way, all read at the accepted set
	for (genvar g = 0; g < NUM_WAYS; g++) begin : g_way
		logic tag_we;
		assign tag_we = look && !res.hit && (pick_way == WAY_W'(g));
		sac_ram #(
			.WIDTH (TAG_BITS),
			.DEPTH (NUM_SETS)
		) u_tag_ram (
			.clk   (clk),
			.we    (tag_we),
			.waddr (set_s1),
			.wdata (tag_s1),
			.raddr (rd_set),
			.rdata (set_tags[g*TAG_BITS +: TAG_BITS])
		);
	end

	// Per-set fill count and most recent way
	sac_ram #(
		.WIDTH (META_W),
		.DEPTH (NUM_SETS)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wr),
		.raddr (rd_set),
		.rdata (meta_rd)
	);

	assign filled = meta_rd[META_W-1 -: CNT_W];
	assign recent = meta_rd[WAY_W-1:0];

	sac_lookup #(
		.NUM_WAYS (NUM_WAYS),
		.TAG_BITS (TAG_BITS),
		.CNT_W    (CNT_W),
		.WAY_W    (WAY_W)
	) u_lookup (
		.ways_cfg (ways_q),
		.set_tags (set_tags),
		.key      (tag_s1),
		.filled   (filled),
		.recent   (recent),
		.res      (res)
	);

	// Write-back of the set metadata; the clear pass uses the same port
	always_comb begin
		pick_way   = WAY_W'(res.way);
		new_fill   = res.fill ? (filled + CNT_W'(1)) : filled;
		meta_we    = look || (state_q == sac_pkg::ST_CLEAR);
		meta_waddr = look ? set_s1 : clr_q;
		meta_wr    = look ? {new_fill, pick_way} : '0;
	end

	// Controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sac_pkg::ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= look;
			case (state_q)
				sac_pkg::ST_CLEAR: begin
					clr_q <= clr_q + SET_W'(1);
					if (clr_q == LAST_SET) begin
						state_q <= sac_pkg::ST_IDLE;
					end
				end
				sac_pkg::ST_IDLE: begin
					if (start) begin
						state_q <= sac_pkg::ST_LOOK;
					end
				end
				sac_pkg::ST_LOOK: begin
					state_q <= sac_pkg::ST_IDLE;
				end
				default: begin
					state_q <= sac_pkg::ST_CLEAR;
					clr_q   <= '0;
				end
			endcase
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q <= sac_pkg::WAYS_REG_W'(NUM_WAYS);
		end else if (cfg_valid && cfg_ready) begin
			ways_q <= sac_pkg::WAYS_REG_W'(cfg_data);
		end
	end

	// Saturating hit and miss totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_tot_q  <= '0;
			miss_tot_q <= '0;
		end else if (look) begin
			if (res.hit && (hit_tot_q != '1)) begin
				hit_tot_q <= hit_tot_q + sac_pkg::CNT_OUT_W'(1);
			end
			if (!res.hit && (miss_tot_q != '1)) begin
				miss_tot_q <= miss_tot_q + sac_pkg::CNT_OUT_W'(1);
			end
		end
	end

	// Access capture and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= rd_set;
			tag_s1 <= TAG_BITS'(tag);
		end
		if (look) begin
			hit_q <= res.hit;
			way_q <= sac_pkg::WAY_OUT_W'(res.way);
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign way        = way_q;
	assign hit_count  = hit_tot_q;
	assign miss_count = miss_tot_q;

endmodule

// ===== rtl/sac_chk.sv =====
// Port-level checker for the cache tag store, bound to the top level.
// Depends on assert_macros.svh and sac_pkg.
`include "assert_macros.svh"

module sac_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic                          hit,
	input logic [sac_pkg::CNT_OUT_W-1:0] hit_count,
	input logic [sac_pkg::CNT_OUT_W-1:0] miss_count
);

	// A transfer makes the block busy for its compare cycle
	`SAC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// Each transfer yields its result via the compare state and then the done register
	`SAC_ASSERT_NOW(a_accept_done, start && !busy, ##2 done)
	// Results never come back to back
	`SAC_ASSERT_NEXT(a_done_single, done, !done)
	// A hit moves the hit total and leaves the miss total alone
	`SAC_ASSERT_NOW(a_hit_totals, done && hit && $past(hit_count) != '1,
		hit_count == $past(hit_count) + 1 && miss_count == $past(miss_count))

endmodule

bind set_assoc_cache_mru_replace sac_chk u_sac_chk (.*);

// ===== sim/set_assoc_cache_mru_replace_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the set-associative MRU cache tag store.
// Depends on sac_pkg and the set_assoc_cache_mru_replace RTL; no other files.
module set_assoc_cache_mru_replace_tb;

	localparam int NUM_SETS    = 64;
	localparam int NUM_WAYS    = 4;
	localparam int TAG_BITS    = 32;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 150;
	localparam int STALL_LIMIT = 2000;

	// One result of an access, as the block reports it
	typedef struct packed {
		logic                          hit;
		logic [sac_pkg::WAY_OUT_W-1:0] way;
		logic [sac_pkg::CNT_OUT_W-1:0] hits;
		logic [sac_pkg::CNT_OUT_W-1:0] misses;
	} access_result_t;

	typedef enum logic [1:0] {
		ROW_LOOKUP,       // result from the predictor
		ROW_LOOKUP_KNOWN, // result typed into the row
		ROW_SET_WAYS      // write the ways-in-use register
	} row_kind_t;

	typedef struct packed {
		row_kind_t                     kind;
		logic [sac_pkg::CFG_W-1:0]     ways;
		logic [sac_pkg::SET_IDX_W-1:0] set_idx;
		logic [sac_pkg::TAG_IN_W-1:0]  tag_val;
		access_result_t                known;
	} dir_row_t;

	localparam access_result_t NONE = '0;

	// Directed sequence: fill set 0, MRU replace, ways lowered below the fill,
	// ways-in-use of zero and above the built count, field extremes.
	localparam dir_row_t DIRECTED [24] = '{
		'{ROW_LOOKUP_KNOWN, 3'd0, 6'd0,  32'h0000_0000, '{1'b0, 2'd0, 32'd0, 32'd1}},
		'{ROW_LOOKUP_KNOWN, 3'd0, 6'd0,  32'h0000_0000, '{1'b1, 2'd0, 32'd1, 32'd1}},
		'{ROW_LOOKUP_KNOWN, 3'd0, 6'd63, 32'hFFFF_FFFF, '{1'b0, 2'd0, 32'd1, 32'd2}},
		'{ROW_LOOKUP_KNOWN, 3'd0, 6'd63, 32'hFFFF_FFFF, '{1'b1, 2'd0, 32'd2, 32'd2}},
		'{ROW_LOOKUP,       3'd0, 6'd0,  32'hFFFF_FFFF, NONE},
		'{ROW_LOOKUP,       3'd0, 6'd0,  32'h0000_0001, NONE},
		'{ROW_LOOKUP,       3'd0, 6'd0,  32'h0000_0002, NONE},
		'{ROW_LOOKUP,       3'd0, 6'd0,  32'h0000_0000, NONE},
		'{ROW_LOOKUP,       3'd0, 6'd0,  32'h0000_0003, NONE},
		'{ROW_LOOKUP,       3'd0, 6'd0,  32'h0000_0003, NONE},
		'{ROW_LOOKUP,       3'd0, 6'd0,  32'h0000_0002, NONE},
		'{ROW_SET_WAYS,     3'd2, 6'd0,  32'h0000_0000, NONE},
		// most recent way (3) is outside the two ways in use: way 0 is replaced
		'{ROW_LOOKUP_KNOWN, 3'd0, 6'd0,  32'h0000_0002, '{1'b0, 2'd0, 32'd5, 32'd7}},
		'{ROW_LOOKUP,       3'd0, 6'd0,  32'hFFFF_FFFF, NONE},
		'{ROW_SET_WAYS,     3'd0, 6'd0,  32'h0000_0000, NONE},
		'{ROW_LOOKUP,       3'd0, 6'd5,  32'hA5A5_A5A5, NONE},
		'{ROW_LOOKUP,       3'd0, 6'd5,  32'h5A5A_5A5A, NONE},
		'{ROW_LOOKUP,       3'd0, 6'd0,  32'hFFFF_FFFF, NONE},
		'{ROW_SET_WAYS,     3'd7, 6'd0,  32'h0000_0000, NONE},
		'{ROW_LOOKUP,       3'd0, 6'd0,  32'h0000_0001, NONE},
		'{ROW_LOOKUP,       3'd0, 6'd5,  32'h1234_5678, NONE},
		'{ROW_LOOKUP,       3'd0, 6'd5,  32'h1234_5678, NONE},
		'{ROW_LOOKUP,       3'd0, 6'd42, 32'h8000_0001, NONE},
		'{ROW_SET_WAYS,     3'd4, 6'd0,  32'h0000_0000, NONE}
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic [sac_pkg::SET_IDX_W-1:0] set_index = '0;
	logic [sac_pkg::TAG_IN_W-1:0]  tag = '0;
	logic                          done;
	logic                          hit;
	logic [sac_pkg::WAY_OUT_W-1:0] way;
	logic [sac_pkg::CNT_OUT_W-1:0] hit_count;
	logic [sac_pkg::CNT_OUT_W-1:0] miss_count;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [sac_pkg::CFG_W-1:0]     cfg_data = '0;

	// Predictor state
	logic [sac_pkg::TAG_IN_W-1:0]  tag_mem [NUM_SETS][NUM_WAYS];
	logic [2:0]                    fill_cnt [NUM_SETS];
	logic [1:0]                    mru_way [NUM_SETS];
	logic [sac_pkg::CNT_OUT_W-1:0] hit_total;
	logic [sac_pkg::CNT_OUT_W-1:0] miss_total;
	logic [sac_pkg::CFG_W-1:0]     ways_reg;

	access_result_t pending_results [$];
	int unsigned    mismatch_cnt = 0;
	bit             burst_mode = 1'b0;

	set_assoc_cache_mru_replace #(
		.NUM_SETS(NUM_SETS),
		.NUM_WAYS(NUM_WAYS),
		.TAG_BITS(TAG_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.set_index(set_index),
		.tag(tag),
		.done(done),
		.hit(hit),
		.way(way),
		.hit_count(hit_count),
		.miss_count(miss_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Tag lookup with MRU replacement; updates the predictor state
	function automatic access_result_t lookup_tag(input logic [sac_pkg::SET_IDX_W-1:0] s,
			input logic [sac_pkg::TAG_IN_W-1:0] t);
		access_result_t r;
		int unsigned    nw;
		int unsigned    filled;
		int unsigned    lim;
		int unsigned    wsel;
		bit             found;
		nw     = (ways_reg == 0) ? 1 : ((ways_reg > NUM_WAYS) ? NUM_WAYS : ways_reg);
		filled = fill_cnt[s];
		lim    = (filled < nw) ? filled : nw;
		found  = 1'b0;
		wsel   = 0;
		for (int w = 0; w < lim; w++) begin
			if (!found && tag_mem[s][w] == t) begin
				found = 1'b1;
				wsel  = w;
			end
		end
		if (found) begin
			if (hit_total != '1)
				hit_total = hit_total + 1;
		end else begin
			if (filled < nw) begin
				wsel        = filled;
				fill_cnt[s] = 3'(filled + 1);
			end else begin
				// full set: overwrite the most recent way if it is still in use
				wsel = (mru_way[s] < nw) ? mru_way[s] : 0;
			end
			tag_mem[s][wsel] = t;
			if (miss_total != '1)
				miss_total = miss_total + 1;
		end
		mru_way[s] = 2'(wsel);
		r.hit    = found;
		r.way    = wsel[sac_pkg::WAY_OUT_W-1:0];
		r.hits   = hit_total;
		r.misses = miss_total;
		return r;
	endfunction

	// Drive one access, wait for its transfer, record the expected result
	task automatic issue_access(input logic [sac_pkg::SET_IDX_W-1:0] s,
			input logic [sac_pkg::TAG_IN_W-1:0] t,
			input bit use_known, input access_result_t known);
		int unsigned    gap;
		access_result_t predicted;
		gap = burst_mode ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		set_index <= s;
		tag       <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
		predicted = lookup_tag(s, t);
		pending_results.push_back(use_known ? known : predicted);
	endtask

	// Register write once every pending result is out
	task automatic write_ways(input logic [sac_pkg::CFG_W-1:0] v);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		ways_reg = v;
		cfg_valid <= 1'b0;
	endtask

	// Stimulus: directed table, then random phases with a new ways setting each
	initial begin
		dir_row_t                      row;
		logic [sac_pkg::SET_IDX_W-1:0] hot_set;
		logic [sac_pkg::SET_IDX_W-1:0] s;
		logic [sac_pkg::TAG_IN_W-1:0]  t;
		logic [sac_pkg::TAG_IN_W-1:0]  tag_pool [6];
		foreach (fill_cnt[i]) begin
			fill_cnt[i] = '0;
			mru_way[i]  = '0;
		end
		hit_total  = '0;
		miss_total = '0;
		ways_reg   = sac_pkg::CFG_W'(NUM_WAYS);
		wait (arst_n === 1'b1);
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			case (row.kind)
				ROW_SET_WAYS:     write_ways(row.ways);
				ROW_LOOKUP_KNOWN: issue_access(row.set_idx, row.tag_val, 1'b1, row.known);
				default:          issue_access(row.set_idx, row.tag_val, 1'b0, NONE);
			endcase
		end

		for (int p = 0; p < PHASES; p++) begin
			write_ways(sac_pkg::CFG_W'($urandom_range(0, 7)));
			burst_mode = (p == 1) || ($urandom_range(0, 3) == 0);
			hot_set    = sac_pkg::SET_IDX_W'($urandom_range(0, NUM_SETS - 1));
			foreach (tag_pool[k])
				tag_pool[k] = $urandom();
			// mostly a few hot sets and a small tag pool, so hits and full sets are common
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 70)
					s = hot_set ^ sac_pkg::SET_IDX_W'($urandom_range(0, 3));
				else
					s = sac_pkg::SET_IDX_W'($urandom_range(0, NUM_SETS - 1));
				if ($urandom_range(0, 99) < 80)
					t = tag_pool[$urandom_range(0, 5)];
				else
					t = $urandom();
				issue_access(s, t, 1'b0, NONE);
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Result checker: every done strobe against the oldest expectation
	always @(posedge clk) begin : check_results
		access_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no access pending");
				mismatch_cnt = mismatch_cnt + 1;
			end else begin
				want = pending_results.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, actual %0d", want.hit, hit);
					mismatch_cnt = mismatch_cnt + 1;
				end
				if (way !== want.way) begin
					$error("way: expected %0d, actual %0d", want.way, way);
					mismatch_cnt = mismatch_cnt + 1;
				end
				if (hit_count !== want.hits) begin
					$error("hit_count: expected %0d, actual %0d", want.hits, hit_count);
					mismatch_cnt = mismatch_cnt + 1;
				end
				if (miss_count !== want.misses) begin
					$error("miss_count: expected %0d, actual %0d", want.misses, miss_count);
					mismatch_cnt = mismatch_cnt + 1;
				end
			end
		end
	end

	// Watchdog: too many cycles without any transfer or result
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet = quiet + 1;
		end
		$display("FAILURE");
		$finish;
	end

endmodule
